/* hw/rtl/mmbd_pkg.sv */
// Shared types and constants for the mipmap box downsampler.
// Holds field widths, register indexes and reset values; depends on nothing.
package mmbd_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PIXEL_W     = CHAN_W * NUM_CHAN;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CHAN_CNT_W  = 3;

    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int MAX_ROWS_DEF    = 4096;

    typedef logic [PIXEL_W-1:0]    t_pixel;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROW_COUNT     = 2'd0;
    localparam t_cfg_idx CFG_COLUMN_COUNT  = 2'd1;
    localparam t_cfg_idx CFG_CHANNEL_COUNT = 2'd2;

    // Register values after reset
    localparam t_cfg_data            ROW_COUNT_RST     = 13'd2;
    localparam t_cfg_data            COLUMN_COUNT_RST  = 13'd2;
    localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = 3'd4;

endpackage

/* hw/rtl/mmbd_if.sv */
// Request channels of the mipmap box downsampler: source pixels, result pixels, config writes.
// Depends on mmbd_pkg for field widths.
interface mmbd_in_if
    import mmbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;

    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                    output ready);
endinterface

interface mmbd_out_if
    import mmbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out0;
    logic [CHAN_W-1:0] out1;
    logic [CHAN_W-1:0] out2;
    logic [CHAN_W-1:0] out3;
    logic              level_end;

    modport source (output valid, output out0, output out1, output out2, output out3,
                    output level_end, input ready);
    modport sink   (input valid, input out0, input out1, input out2, input out3,
                    input level_end, output ready);
endinterface

interface mmbd_cfg_if
    import mmbd_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mmbd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module mmbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mipmap_box_downsampler.sv */
// Top level of the mipmap box downsampler: 2x2 box filter over a raster pixel stream.
// Depends on mmbd_pkg, the mmbd_*_if interfaces and mmbd_ram.
//
// Usage:
//   i_cfg  : register writes (row_count, column_count, channel_count). Always ready.
//            Write only while the block is idle; any write to a known register
//            restarts the frame at row 0, column 0.
//   i_pix  : source pixels in raster order, one request per pixel.
//   o_pix  : downsampled pixels; level_end marks the last pixel of the level.
// Path: the source pixel that completes a 2x2 block (or pair, for a one-row or one-column
//   source) passes the input stage register and then the result register to o_pix.
// Throughput: one source pixel per clock while i_pix is ready. Each pixel does one
//   read and at most one write on each of the two pair line buffers (even-row buffer,
//   first-row buffer), which store two horizontally adjacent pixels per word.
// Reset: counts return to 2 rows, 2 columns, 4 channels, position to the frame
//   origin; the line buffers are not cleared and need no clearing pass.
// Stall: when o_pix is not ready the result register holds, one more result
//   waits in the stage before it, and i_pix drops ready only when both are full.
module mipmap_box_downsampler
    import mmbd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mmbd_cfg_if.sink     i_cfg,
    mmbd_in_if.sink      i_pix,
    mmbd_out_if.source   o_pix
);

    localparam int PW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int PAIRS = (MAX_COLUMNS + 1) / 2;
    localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    typedef struct packed {
        t_pixel px;
        t_pixel prev;
        t_pixel even_first;
        t_pixel odd_first;
        t_pixel first_px;
        logic   line_mode;
        logic   last_row;
        logic   last_col;
    } t_stage;

    // Configuration registers
    t_cfg_data              r_row_count;
    t_cfg_data              r_column_count;
    logic [CHAN_CNT_W-1:0]  r_channel_count;

    // Frame position and per-pixel state
    logic [RW-1:0]          r_row_pos;
    logic [PW-1:0]          r_col_pos;
    t_pixel                 r_prev_pixel;
    t_pixel                 r_even_first;
    t_pixel                 r_odd_first;
    t_pixel                 r_first_pixel;

    // Pipeline registers
    logic                   r_s1_valid;
    t_stage                 r_s1;
    logic                   r_out_valid;
    t_pixel                 r_out_px;
    logic                   r_out_end;
    t_pixel                 n_out_px;
    logic                   n_out_end;

    logic [RCW-1:0]         rows;
    logic [CW-1:0]          cols;
    logic [RCW-1:0]         rend;
    logic [CW-1:0]          cend;
    logic                   rows_multi;
    logic                   cols_multi;
    logic                   row_last;
    logic                   col_last;
    logic                   row_wrap;
    logic                   col_wrap;
    logic                   produce;
    t_pixel                 cur_px;
    logic                   pix_acc;
    logic                   cfg_acc;
    logic                   cfg_hit;
    logic                   out_free;
    logic                   even_we;
    logic                   first_we;
    logic [PAW-1:0]         pair_addr;
    logic [2*PIXEL_W-1:0]   pair_wdata;
    logic [2*PIXEL_W-1:0]   even_rdata;
    logic [2*PIXEL_W-1:0]   first_rdata;

    // Clamp the counts to 1..max
    always_comb begin
        if (r_row_count == '0) begin
            rows = RCW'(1);
        end else if (32'(r_row_count) > 32'(MAX_ROWS)) begin
            rows = RCW'(MAX_ROWS);
        end else begin
            rows = RCW'(r_row_count);
        end
        if (r_column_count == '0) begin
            cols = CW'(1);
        end else if (32'(r_column_count) > 32'(MAX_COLUMNS)) begin
            cols = CW'(MAX_COLUMNS);
        end else begin
            cols = CW'(r_column_count);
        end
    end

    // Classify the incoming pixel
    assign cur_px     = {i_pix.chan3, i_pix.chan2, i_pix.chan1, i_pix.chan0};
    assign rend       = {rows[RCW-1:1], 1'b0};
    assign cend       = {cols[CW-1:1], 1'b0};
    assign rows_multi = (rows != RCW'(1));
    assign cols_multi = (cols != CW'(1));
    assign row_last   = ((RCW'(r_row_pos) + RCW'(1)) == rend);
    assign col_last   = ((CW'(r_col_pos) + CW'(1)) == cend);
    assign row_wrap   = ((RCW'(r_row_pos) + RCW'(1)) == rows);
    assign col_wrap   = ((CW'(r_col_pos) + CW'(1)) == cols);

    // An odd position always lies inside the even-sized part of the frame
    always_comb begin
        if (rows_multi && cols_multi) begin
            produce = r_row_pos[0] && r_col_pos[0];
        end else if (cols_multi) begin
            produce = r_col_pos[0];
        end else if (rows_multi) begin
            produce = r_row_pos[0];
        end else begin
            produce = 1'b0;
        end
    end

    // Handshakes
    assign out_free    = !r_out_valid || o_pix.ready;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign i_cfg.ready = 1'b1;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign cfg_hit     = cfg_acc && (i_cfg.index == CFG_ROW_COUNT ||
                                     i_cfg.index == CFG_COLUMN_COUNT ||
                                     i_cfg.index == CFG_CHANNEL_COUNT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= ROW_COUNT_RST;
            r_column_count  <= COLUMN_COUNT_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_ROW_COUNT:     r_row_count     <= i_cfg.data;
                CFG_COLUMN_COUNT:  r_column_count  <= i_cfg.data;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[CHAN_CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Advance the frame position; restart on a write to a known register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (cfg_hit) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (pix_acc) begin
            if (col_wrap) begin
                r_col_pos <= '0;
                r_row_pos <= row_wrap ? '0 : r_row_pos + RW'(1);
            end else begin
                r_col_pos <= r_col_pos + PW'(1);
            end
        end
    end

    // Track previous pixel and the column-0 pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pixel  <= '0;
            r_even_first  <= '0;
            r_odd_first   <= '0;
            r_first_pixel <= '0;
        end else if (pix_acc) begin
            r_prev_pixel <= cur_px;
            if (r_col_pos == '0) begin
                if (r_row_pos[0]) begin
                    r_odd_first <= cur_px;
                end else begin
                    r_even_first <= cur_px;
                end
                if (r_row_pos == '0) begin
                    r_first_pixel <= cur_px;
                end
            end
        end
    end

    // Pair line buffers: word holds columns 2k (low) and 2k+1 (high)
    assign pair_addr  = PAW'(r_col_pos >> 1);
    assign pair_wdata = {cur_px, r_prev_pixel};
    assign even_we    = pix_acc && !r_row_pos[0] && r_col_pos[0];
    assign first_we   = pix_acc && (r_row_pos == '0) && r_col_pos[0];

    mmbd_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (PAIRS),
        .AW    (PAW)
    ) u_even_ram (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (pair_addr),
        .i_wdata (pair_wdata),
        .i_re    (pix_acc),
        .i_raddr (pair_addr),
        .o_rdata (even_rdata)
    );

    mmbd_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (PAIRS),
        .AW    (PAW)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (first_we),
        .i_waddr (pair_addr),
        .i_wdata (pair_wdata),
        .i_re    (pix_acc),
        .i_raddr (pair_addr),
        .o_rdata (first_rdata)
    );

    // Input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= pix_acc && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1.px         <= cur_px;
            r_s1.prev       <= r_prev_pixel;
            r_s1.even_first <= r_even_first;
            r_s1.odd_first  <= r_odd_first;
            r_s1.first_px   <= r_first_pixel;
            r_s1.line_mode  <= !(rows_multi && cols_multi);
            r_s1.last_row   <= row_last;
            r_s1.last_col   <= cols_multi ? col_last : row_last;
        end
    end

    // Select the samples and average per channel
    always_comb begin
        t_pixel            s_ap;
        t_pixel            s_aq;
        t_pixel            s_bp;
        t_pixel            s_bq;
        logic [CHAN_W-1:0] v;
        s_ap = even_rdata[PIXEL_W-1:0];
        s_aq = r_s1.last_col ? r_s1.even_first : even_rdata[2*PIXEL_W-1:PIXEL_W];
        if (r_s1.last_row) begin
            s_bp = first_rdata[PIXEL_W-1:0];
            s_bq = r_s1.last_col ? r_s1.first_px : first_rdata[2*PIXEL_W-1:PIXEL_W];
        end else begin
            s_bp = r_s1.prev;
            s_bq = r_s1.last_col ? r_s1.odd_first : r_s1.px;
        end
        n_out_px = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (r_s1.line_mode) begin
                v = (r_s1.prev[CHAN_W*k +: CHAN_W] >> 1) +
                    ((r_s1.last_col ? r_s1.first_px[CHAN_W*k +: CHAN_W]
                                    : r_s1.px[CHAN_W*k +: CHAN_W]) >> 1);
            end else begin
                v = (s_ap[CHAN_W*k +: CHAN_W] >> 2) + (s_bp[CHAN_W*k +: CHAN_W] >> 2) +
                    (s_bq[CHAN_W*k +: CHAN_W] >> 2) + (s_aq[CHAN_W*k +: CHAN_W] >> 2);
            end
            if (CHAN_CNT_W'(k) < r_channel_count) begin
                n_out_px[CHAN_W*k +: CHAN_W] = v;
            end
        end
        n_out_end = r_s1.line_mode ? r_s1.last_col : (r_s1.last_row && r_s1.last_col);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_px  <= n_out_px;
            r_out_end <= n_out_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out0      = r_out_px[CHAN_W-1:0];
    assign o_pix.out1      = r_out_px[2*CHAN_W-1:CHAN_W];
    assign o_pix.out2      = r_out_px[3*CHAN_W-1:2*CHAN_W];
    assign o_pix.out3      = r_out_px[4*CHAN_W-1:3*CHAN_W];
    assign o_pix.level_end = r_out_end;

`ifndef SYNTHESIS
    // Column position stays inside the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col_pos) < cols)
        else $error("column position beyond row length");

    // Full pipeline blocks new pixels
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |-> !i_pix.ready)
        else $error("pixel taken while both result stages are full");

    // Register write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_row_pos == '0 && r_col_pos == '0))
        else $error("frame not restarted after register write");
`endif

endmodule

/* test/tb_mipmap_box_downsampler.sv */
// Self-checking testbench for mipmap_box_downsampler: directed, stall, extreme, random.
// Depends on mmbd_pkg, the mmbd_*_if interfaces and the mipmap_box_downsampler RTL.
`timescale 1ns / 1ps

module tb_mipmap_box_downsampler;
    import mmbd_pkg::*;

    localparam int COL_LIMIT      = MAX_COLUMNS_DEF;
    localparam int ROW_LIMIT      = MAX_ROWS_DEF;
    localparam int RANDOM_PIXELS  = 1100;
    localparam int LINE_PIXELS    = 128;
    localparam int TALL_PIXELS    = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // Index past the last register; writes to it must be ignored
    localparam t_cfg_idx CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] chans;
        logic                            level_end;
    } t_mip_pixel;

    typedef struct packed {
        bit         is_write;
        t_cfg_idx   index;
        t_cfg_data  value;
        t_pixel     pixel;
        bit         typed;
        t_mip_pixel result;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmbd_cfg_if cfg_if ();
    mmbd_in_if  pix_if ();
    mmbd_out_if res_if ();

    mipmap_box_downsampler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_pix   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: registers, line stores and frame position
    t_cfg_data             rows_reg;
    t_cfg_data             cols_reg;
    logic [CHAN_CNT_W-1:0] chans_reg;
    t_pixel                first_row [COL_LIMIT];
    t_pixel                even_row  [COL_LIMIT];
    t_pixel                even_first;
    t_pixel                odd_first;
    t_pixel                prev_px;
    int unsigned           row_pos;
    int unsigned           col_pos;

    t_mip_pixel pending_mip_pixels [$];
    t_stim_row  directed_rows [$];
    int         mismatch_count = 0;
    int         pixels_sent = 0;
    int         src_idle_pct = 30;
    int         rx_idle_pct = 87;
    bit         hold_request = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    function automatic int unsigned eff_count(input t_cfg_data v, input int unsigned max);
        if (v == 0) return 1;
        if (v > max) return max;
        return v;
    endfunction

    function automatic void apply_write(input t_cfg_idx idx, input t_cfg_data val);
        case (idx)
            CFG_ROW_COUNT:     rows_reg = val;
            CFG_COLUMN_COUNT:  cols_reg = val;
            CFG_CHANNEL_COUNT: chans_reg = val[CHAN_CNT_W-1:0];
            default:           return;
        endcase
        // any known register restarts the frame
        row_pos = 0;
        col_pos = 0;
    endfunction

    // Advance the frame by one source pixel; return 1 with the downsampled pixel it completes
    function automatic bit downsample_pixel(input t_pixel px, output t_mip_pixel res);
        int unsigned rows, cols, nch, r, c, row_end, col_end, span, pos;
        bit          last_r, last_c, hit;
        t_pixel      a0, a1, b0, b1;
        rows = eff_count(rows_reg, ROW_LIMIT);
        cols = eff_count(cols_reg, COL_LIMIT);
        nch  = (chans_reg > NUM_CHAN) ? NUM_CHAN : chans_reg;
        r    = (row_pos >= rows) ? 0 : row_pos;
        c    = (col_pos >= cols) ? 0 : col_pos;
        hit  = 1'b0;
        res  = '0;

        // capture row 0, the latest even row and the first pixel of each row
        if (r == 0) first_row[c] = px;
        if (r % 2 == 0) begin
            even_row[c] = px;
            if (c == 0) even_first = px;
        end else if (c == 0) begin
            odd_first = px;
        end

        if (rows >= 2 && cols >= 2) begin
            row_end = 2 * (rows / 2);
            col_end = 2 * (cols / 2);
            if (r % 2 == 1 && c % 2 == 1 && r < row_end && c < col_end) begin
                last_r = (r + 1 == row_end);
                last_c = (c + 1 == col_end);
                a0 = even_row[c - 1];
                a1 = last_c ? even_first : even_row[c];
                // the last output row wraps to row 0, the last column to column 0
                if (last_r) begin
                    b0 = first_row[c - 1];
                    b1 = last_c ? first_row[0] : first_row[c];
                end else begin
                    b0 = prev_px;
                    b1 = last_c ? odd_first : px;
                end
                for (int k = 0; k < nch; k++)
                    res.chans[k] = 8'(a0[8*k +: 8] / 4 + a1[8*k +: 8] / 4 +
                                      b0[8*k +: 8] / 4 + b1[8*k +: 8] / 4);
                res.level_end = last_r && last_c;
                hit = 1'b1;
            end
        end else if (rows >= 2 || cols >= 2) begin
            // one row or one column: average pairs along the line
            span = (cols >= 2) ? cols : rows;
            pos  = (cols >= 2) ? c : r;
            if (pos % 2 == 1 && pos < 2 * (span / 2)) begin
                last_r = (pos + 1 == 2 * (span / 2));
                a1 = last_r ? first_row[0] : px;
                for (int k = 0; k < nch; k++)
                    res.chans[k] = 8'(prev_px[8*k +: 8] / 2 + a1[8*k +: 8] / 2);
                res.level_end = last_r;
                hit = 1'b1;
            end
        end

        // advance the raster position
        prev_px = px;
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        row_pos = r;
        col_pos = c;
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Write one register; drain the datapath first unless a write request is already up
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        if (!cfg_if.valid) begin
            pix_if.valid <= 1'b0;
            while (pending_mip_pixels.size() != 0) @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_write(idx, val);
        @(negedge i_clk);
    endtask

    task automatic program_frame(input t_cfg_data rows, input t_cfg_data cols,
                                 input logic [CHAN_CNT_W-1:0] chans);
        t_cfg_data chan_word;
        // random upper bits must be dropped by the channel count register
        chan_word = t_cfg_data'($urandom);
        chan_word[CHAN_CNT_W-1:0] = chans;
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_CHANNEL_COUNT, chan_word);
    endtask

    // Offer one source pixel and queue what it should produce
    task automatic send_pixel(input t_pixel px, input bit typed, input t_mip_pixel typed_res);
        t_mip_pixel res;
        bit         hit;
        if (cfg_if.valid) cfg_if.valid <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        {pix_if.chan3, pix_if.chan2, pix_if.chan1, pix_if.chan0} <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        hit = downsample_pixel(px, res);
        if (typed) pending_mip_pixels = {pending_mip_pixels, typed_res};
        else if (hit) pending_mip_pixels = {pending_mip_pixels, res};
        @(negedge i_clk);
    endtask

    task automatic send_random_pixels(input int count);
        t_pixel px;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < NUM_CHAN; k++)
                case ($urandom_range(7))
                    0:       px[8*k +: 8] = '0;
                    1:       px[8*k +: 8] = '1;
                    default: px[8*k +: 8] = 8'($urandom);
                endcase
            send_pixel(px, 1'b0, '0);
            pixels_sent++;
        end
    endtask

    function automatic void add_write(input t_cfg_idx idx, input t_cfg_data val);
        t_stim_row row;
        row = '0;
        row.is_write = 1'b1;
        row.index = idx;
        row.value = val;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_pixel(input t_pixel px);
        t_stim_row row;
        row = '0;
        row.pixel = px;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_result_pixel(input t_pixel px, input t_pixel chans,
                                             input bit level_end);
        t_stim_row row;
        row = '0;
        row.pixel = px;
        row.typed = 1'b1;
        row.result.chans = chans;
        row.result.level_end = level_end;
        directed_rows = {directed_rows, row};
    endfunction

    // Drive the result-side ready: random idling plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_mip_pixel want, got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.chans = {res_if.out3, res_if.out2, res_if.out1, res_if.out0};
            got.level_end = res_if.level_end;
            if (pending_mip_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h end %b", got.chans,
                                          got.level_end));
            end else begin
                want = pending_mip_pixels.pop_front();
                for (int k = 0; k < NUM_CHAN; k++)
                    if (got.chans[k] !== want.chans[k])
                        report_mismatch($sformatf("out%0d expected %h got %h", k,
                                                  want.chans[k], got.chans[k]));
                if (got.level_end !== want.level_end)
                    report_mismatch($sformatf("level_end expected %b got %b",
                                              want.level_end, got.level_end));
            end
        end
    end

    // End the run when no request of any kind moves for too long
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mipmap_box_downsampler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg_data   rows_val;
        t_cfg_data   cols_val;
        int unsigned frame;
        int unsigned count;
        int unsigned cut;
        int          random_start;
        int          progress;

        // hold every input at a known value through reset
        i_rst_n       = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_ROW_COUNT;
        cfg_if.data   = '0;
        pix_if.valid  = 1'b0;
        pix_if.chan0  = '0;
        pix_if.chan1  = '0;
        pix_if.chan2  = '0;
        pix_if.chan3  = '0;
        res_if.ready  = 1'b0;
        rows_reg      = ROW_COUNT_RST;
        cols_reg      = COLUMN_COUNT_RST;
        chans_reg     = CHANNEL_COUNT_RST;
        even_first    = '0;
        odd_first     = '0;
        prev_px       = '0;
        row_pos       = 0;
        col_pos       = 0;

        // 2x2 after reset: every sample wraps to pixel 0, so only it matters
        add_pixel(32'hffffffff);
        add_pixel(32'h00000000);
        add_pixel(32'h00000000);
        add_result_pixel(32'h00000000, 32'hfcfcfcfc, 1'b1);
        add_pixel(32'hff0b0703);
        add_pixel(32'hffffffff);
        add_pixel(32'hffffffff);
        add_result_pixel(32'hffffffff, 32'hfc080400, 1'b1);
        // zero channels: every output channel reads zero
        add_write(CFG_CHANNEL_COUNT, 13'd0);
        add_pixel(32'hffffffff);
        add_pixel(32'hffffffff);
        add_pixel(32'hffffffff);
        add_result_pixel(32'hffffffff, 32'h00000000, 1'b1);
        // index past the register file, then single pixel frames: no output
        add_write(CFG_UNUSED_INDEX, 13'h1fff);
        add_write(CFG_CHANNEL_COUNT, 13'd3);
        add_write(CFG_ROW_COUNT, 13'd0);
        add_write(CFG_COLUMN_COUNT, 13'd0);
        add_pixel(32'h12345678);
        add_pixel(32'h9abcdef0);
        // one row of two: the pair wraps to element 0 and halves it twice
        add_write(CFG_COLUMN_COUNT, 13'd2);
        add_pixel(32'hffffffff);
        add_result_pixel(32'h01010101, 32'h00fefefe, 1'b1);
        // one row of five: the odd leftover element is dropped
        add_write(CFG_CHANNEL_COUNT, 13'd4);
        add_write(CFG_COLUMN_COUNT, 13'd5);
        add_pixel(32'h01fe7f80);
        add_pixel(32'hff00aa55);
        add_pixel(32'h12345678);
        add_pixel(32'h9abcdef0);
        add_pixel(32'hdeadbeef);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write)
                write_reg(directed_rows[i].index, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                           directed_rows[i].result);
        end

        // long receiver hold on a small frame so the input stalls
        program_frame(13'd4, 13'd4, 3'd4);
        hold_request = 1'b1;
        send_random_pixels(48);

        // count extremes: the start of a saturated line, then partial max-sized frames
        program_frame(13'd1, 13'h1fff, 3'd4);
        send_random_pixels(LINE_PIXELS);
        program_frame(13'h1fff, 13'd3, 3'd2);
        send_random_pixels(TALL_PIXELS);
        program_frame(13'd4096, 13'd4096, 3'd1);
        send_random_pixels(64);

        // random frames, idling shifted between the two sides by thirds
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            progress = pixels_sent - random_start;
            if (progress < RANDOM_PIXELS / 3) begin
                src_idle_pct = 30;
                rx_idle_pct  = 87;
            end else if (progress < 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 87;
                rx_idle_pct  = 30;
            end else begin
                src_idle_pct = 0;
                rx_idle_pct  = 0;
            end

            case ($urandom_range(9))
                0:       rows_val = 13'd0;
                1:       rows_val = 13'd1;
                2:       rows_val = 13'd2;
                default: rows_val = t_cfg_data'($urandom_range(9, 3));
            endcase
            case ($urandom_range(9))
                0:       cols_val = 13'd0;
                1:       cols_val = 13'd1;
                2:       cols_val = 13'd2;
                default: cols_val = t_cfg_data'($urandom_range(12, 3));
            endcase
            program_frame(rows_val, cols_val, CHAN_CNT_W'($urandom_range(7)));

            frame = eff_count(rows_val, ROW_LIMIT) * eff_count(cols_val, COL_LIMIT);
            count = frame * $urandom_range(3, 1);
            if (count > 1 && $urandom_range(3) == 0) begin
                // drop a write to the unused index mid-frame; the frame carries on
                cut = $urandom_range(count - 1, 1);
                send_random_pixels(cut);
                write_reg(CFG_UNUSED_INDEX, t_cfg_data'($urandom));
                send_random_pixels(count - cut);
            end else begin
                send_random_pixels(count);
            end
            // leave a frame unfinished now and then so the next write restarts it
            if ($urandom_range(4) == 0)
                send_random_pixels($urandom_range(frame, 1));
        end

        // drain and give the verdict
        pix_if.valid <= 1'b0;
        while (pending_mip_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("mipmap_box_downsampler regression: pass");
        else
            $display("mipmap_box_downsampler regression: fail");
        $finish;
    end

endmodule

/* mipmap_box_downsampler.f */
hw/rtl/mmbd_pkg.sv
hw/rtl/mmbd_if.sv
hw/rtl/mmbd_ram.sv
hw/rtl/mipmap_box_downsampler.sv
test/tb_mipmap_box_downsampler.sv
